[design/assert_macros.svh]
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[design/mmq_pkg.sv]
`default_nettype none
package mmq_pkg;

    localparam int NOTE_COUNT   = 128;
    localparam int TPI_W        = 21;
    localparam int DELTA_W      = 28;
    localparam int TOTAL_W      = DELTA_W + 1;
    localparam int DIV_STEPS    = TOTAL_W;
    localparam int STEP_W       = $clog2(DIV_STEPS + 1);
    localparam int GROUP_SIZE   = 16;
    localparam int GSEL_W       = $clog2(GROUP_SIZE);
    localparam int GROUP_COUNT  = (NOTE_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_W      = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    localparam logic [TPI_W-1:0]   TPI_RESET       = 21'd120;
    localparam logic [7:0]         STATUS_MASK     = 8'hF0;
    localparam logic [7:0]         STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0]         STATUS_NOTE_OFF = 8'h80;
    localparam logic [DELTA_W-1:0] COUNT_MAX       = 28'hFFF_FFFF;
    localparam logic signed [7:0]  NO_NOTE         = -8'sd1;

    typedef struct packed {
        logic [DELTA_W-1:0] delta_ticks;
        logic [7:0]         event_status;
        logic [6:0]         note_number;
        logic [6:0]         note_velocity;
    } t_in;

    typedef struct packed {
        logic signed [7:0]  active_note;
        logic [DELTA_W-1:0] repeat_count;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic has_result;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[design/mmq_div.sv]
`default_nettype none
module mmq_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire  [mmq_pkg::TOTAL_W-1:0]    i_dividend,
    input  wire  [mmq_pkg::TPI_W-1:0]      i_divisor,
    output logic                           o_done,
    output logic [mmq_pkg::TOTAL_W-1:0]    o_quotient,
    output logic [mmq_pkg::TPI_W-1:0]      o_remainder
);
    import mmq_pkg::*;

    logic [STEP_W-1:0]  r_cnt;
    logic [TOTAL_W-1:0] r_quo;
    logic [TPI_W-1:0]   r_rem;
    logic [TPI_W-1:0]   r_dsr;
    logic [TPI_W:0]     w_shift;
    logic [TPI_W:0]     w_diff;

    // restoring division, one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[TOTAL_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STEP_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!w_diff[TPI_W]) begin
                r_rem <= w_diff[TPI_W-1:0];
                r_quo <= {r_quo[TOTAL_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[TPI_W-1:0];
                r_quo <= {r_quo[TOTAL_W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = (r_cnt == '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule
`default_nettype wire

[design/mmq_notes.sv]
`default_nettype none
module mmq_notes (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_apply,
    input  wire  [7:0]          i_status,
    input  wire  [6:0]          i_note,
    input  wire  [6:0]          i_vel,
    output logic                o_done,
    output logic signed [7:0]   o_highest
);
    import mmq_pkg::*;

    localparam int PAD_W = GROUP_COUNT * GROUP_SIZE;

    logic [NOTE_COUNT-1:0] r_held;
    logic [GROUP_W-1:0]    r_grp;
    logic                  r_active;
    logic                  r_found;
    logic signed [7:0]     r_best;
    logic [PAD_W-1:0]      w_pad;
    logic [GROUP_SIZE-1:0] w_bits;
    logic [GSEL_W-1:0]     w_hit;
    logic                  w_is_on;
    logic                  w_is_off;
    logic                  w_in_range;

    assign w_pad  = PAD_W'(r_held);
    assign w_bits = w_pad[r_grp*GROUP_SIZE +: GROUP_SIZE];

    // highest set bit inside the current group
    always_comb begin
        w_hit = '0;
        for (int k = 0; k < GROUP_SIZE; k++) begin
            if (w_bits[k]) begin
                w_hit = GSEL_W'(k);
            end
        end
    end

    // groups are scanned from the top down, first hit wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (r_active && (r_grp == '0 || r_found || (|w_bits))) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_grp   <= GROUP_W'(GROUP_COUNT - 1);
            r_found <= 1'b0;
            r_best  <= NO_NOTE;
        end else if (r_active && !r_found) begin
            if (|w_bits) begin
                r_found <= 1'b1;
                r_best  <= 8'({r_grp, w_hit});
            end else if (r_grp != '0) begin
                r_grp <= r_grp - 1'b1;
            end
        end
    end

    assign w_is_on    = ((i_status & STATUS_MASK) == STATUS_NOTE_ON);
    assign w_is_off   = ((i_status & STATUS_MASK) == STATUS_NOTE_OFF);
    assign w_in_range = ({1'b0, i_note} < 8'(NOTE_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_apply && w_in_range && (w_is_on || w_is_off)) begin
            for (int k = 0; k < NOTE_COUNT; k++) begin
                if (7'(k) == i_note) begin
                    r_held[k] <= w_is_on && (i_vel != '0);
                end
            end
        end
    end

    assign o_done    = !r_active;
    assign o_highest = r_best;
endmodule
`default_nettype wire

[design/mmq_datapath.sv]
`default_nettype none
module mmq_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [mmq_pkg::TPI_W-1:0] i_cfg_wdata,
    input  mmq_pkg::t_in         i_in_data,
    input  mmq_pkg::t_cmd        i_cmd,
    output mmq_pkg::t_stat       o_stat,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output mmq_pkg::t_out        o_out_data
);
    import mmq_pkg::*;

    logic [TPI_W-1:0]   r_tpi;
    logic [TPI_W-1:0]   r_resid;
    logic [7:0]         r_status;
    logic [6:0]         r_note;
    logic [6:0]         r_vel;
    logic               r_out_valid;
    t_out               r_out_data;
    logic [TOTAL_W-1:0] w_total;
    logic [TPI_W-1:0]   w_divisor;
    logic               w_div_done;
    logic [TOTAL_W-1:0] w_quo;
    logic [TPI_W-1:0]   w_rem;
    logic               w_scan_done;
    logic signed [7:0]  w_highest;
    logic [DELTA_W-1:0] w_count;
    logic               w_load_out;

    assign w_total   = TOTAL_W'(r_resid) + TOTAL_W'(i_in_data.delta_ticks);
    // a zero interval register counts as one
    assign w_divisor = (r_tpi == '0) ? TPI_W'(1) : r_tpi;

    mmq_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.start),
        .i_dividend  (w_total),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    mmq_notes u_notes (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.start),
        .i_apply   (i_cmd.finish),
        .i_status  (r_status),
        .i_note    (r_note),
        .i_vel     (r_vel),
        .o_done    (w_scan_done),
        .o_highest (w_highest)
    );

    // saturate the interval count at the field maximum
    assign w_count    = w_quo[TOTAL_W-1] ? COUNT_MAX : w_quo[DELTA_W-1:0];
    assign w_load_out = i_cmd.finish && (w_quo != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpi <= TPI_RESET;
        end else if (i_cfg_we) begin
            r_tpi <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resid <= '0;
        end else if (i_cmd.finish) begin
            r_resid <= w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_status <= i_in_data.event_status;
            r_note   <= i_in_data.note_number;
            r_vel    <= i_in_data.note_velocity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data.active_note  <= w_highest;
            r_out_data.repeat_count <= w_count;
        end
    end

    assign o_stat.div_done   = w_div_done;
    assign o_stat.scan_done  = w_scan_done;
    assign o_stat.has_result = (w_quo != '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
endmodule
`default_nettype wire

[design/mmq_ctrl.sv]
`default_nettype none
module mmq_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  mmq_pkg::t_stat  i_stat,
    output mmq_pkg::t_cmd   o_cmd
);
    import mmq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.div_done && i_stat.scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_stat.has_result || i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // no transfer while reset is held
                o_in_ready  = i_rst_n;
                o_cmd.start = i_in_valid && i_rst_n;
            end
            ST_RUN: begin
            end
            ST_FINISH: begin
                // hold a result's commit until the output register can take it
                o_cmd.finish = !i_stat.has_result || i_stat.out_free;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

[design/midi_monophonic_quantizer.sv]
`default_nettype none
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    t_in  (delta, status, note, velocity)
// out       output     o_out_valid / i_out_ready  t_out (active note, repeat count)
// cfg       input      i_cfg_we                   ticks per interval, 21 bits
//
// an event is taken in, then the serial divider splits the tick sum by the
// interval length in 29 steps; once divider and note scan are seen done, the event commits
// the highest held note is found in 16-note groups while the divider runs
// reset is synchronous: all note flags and the residual clear
// a full output register stalls only a commit with a result; one event at a time
module midi_monophonic_quantizer (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire  [mmq_pkg::TPI_W-1:0] i_cfg_wdata,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  mmq_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output mmq_pkg::t_out             o_out_data
);
    import mmq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mmq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

[design/mmq_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module mmq_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_in_valid,
    input wire           o_in_ready,
    input wire           o_out_valid,
    input wire           i_out_ready,
    input mmq_pkg::t_out o_out_data
);
    import mmq_pkg::*;

    // a waiting result stays offered
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)

    // one event at a time: no transfer on the next cycle
    `ASSERT_RST(a_in_busy, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

    // a result always covers at least one interval
    `ASSERT_RST(a_count_nz, i_clk, i_rst_n, o_out_valid |-> o_out_data.repeat_count != '0)

    // note is a real note number or the no-note code
    `ASSERT_RST(a_note_ok, i_clk, i_rst_n,
        o_out_valid |-> (!o_out_data.active_note[7] || o_out_data.active_note == NO_NOTE))

    // reset empties the output register
    `ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid)
endmodule

bind midi_monophonic_quantizer mmq_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
